[hw/rtl/bsp_point_locator_assert.svh]
// Assertion macros used by the BSP point locator datapath.
`ifndef BSP_POINT_LOCATOR_ASSERT_SVH
`define BSP_POINT_LOCATOR_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define BSP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsp_point_locator: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define BSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsp_point_locator: next-cycle check failed");

`endif

[hw/rtl/bsp_pkg.sv]
// Types and constants of the BSP point locator.
package bsp_pkg;

   localparam int TABLE_DEPTH   = 4096;
   localparam int NODE_AW       = 12;
   localparam int COUNT_W       = 13;
   localparam int FRAC_BITS     = 16;
   localparam int LEAF_BIT      = 15;
   localparam int SUB_W         = 15;
   localparam int MAX_NODES_DEF = 4096;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [11:0]        node_index;
      logic signed [31:0] part_x;
      logic signed [31:0] part_y;
      logic signed [31:0] part_dx;
      logic signed [31:0] part_dy;
      logic [15:0]        front_child;
      logic [15:0]        back_child;
      logic signed [31:0] query_x;
      logic signed [31:0] query_y;
   } req_type;

   typedef struct packed {
      logic [14:0] subsector_index;
      logic        walk_error;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic [15:0]        front;
      logic [15:0]        back;
   } node_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUB,
      ST_MUL,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept_write;
      logic accept_query;
      logic rd_en;
      logic sub_en;
      logic mul_en;
      logic decide_en;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic walk_done;
      logic rsp_free;
   } status_type;

endpackage

[hw/rtl/bsp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry, read one entry into the output register.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/bsp_ctrl.sv]
// Controller state machine of the BSP point locator walk.
module bsp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_mode,
   output logic                 req_ready,
   input  bsp_pkg::status_type  status,
   output bsp_pkg::cmd_type     cmd
);

   bsp_pkg::state_type state_ff, state_in;

   // Advance the state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsp_pkg::ST_IDLE: begin
            if (req_valid && (req_mode == bsp_pkg::MODE_QUERY)) begin
               state_in = status.count_zero ? bsp_pkg::ST_FINISH : bsp_pkg::ST_READ;
            end
         end
         bsp_pkg::ST_READ:   state_in = bsp_pkg::ST_SUB;
         bsp_pkg::ST_SUB:    state_in = bsp_pkg::ST_MUL;
         bsp_pkg::ST_MUL:    state_in = bsp_pkg::ST_DECIDE;
         bsp_pkg::ST_DECIDE: begin
            state_in = status.walk_done ? bsp_pkg::ST_FINISH : bsp_pkg::ST_READ;
         end
         bsp_pkg::ST_FINISH: begin
            if (status.rsp_free) begin
               state_in = bsp_pkg::ST_IDLE;
            end
         end
         default: state_in = bsp_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         bsp_pkg::ST_IDLE: begin
            req_ready        = 1'b1;
            cmd.accept_write = req_valid && (req_mode == bsp_pkg::MODE_WRITE);
            cmd.accept_query = req_valid && (req_mode == bsp_pkg::MODE_QUERY);
         end
         bsp_pkg::ST_READ:   cmd.rd_en     = 1'b1;
         bsp_pkg::ST_SUB:    cmd.sub_en    = 1'b1;
         bsp_pkg::ST_MUL:    cmd.mul_en    = 1'b1;
         bsp_pkg::ST_DECIDE: cmd.decide_en = 1'b1;
         bsp_pkg::ST_FINISH: cmd.load_rsp  = status.rsp_free;
         default: ;
      endcase
   end

endmodule

[hw/rtl/bsp_datapath.sv]
// Datapath of the BSP point locator: node table, side test, walk state, response.
`include "bsp_point_locator_assert.svh"

module bsp_datapath #(
   parameter int MAX_NODES = bsp_pkg::MAX_NODES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bsp_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bsp_pkg::rsp_type              rsp_payload,
   input  logic                          csr_wr_en,
   input  logic [bsp_pkg::COUNT_W-1:0]   csr_wr_data,
   input  bsp_pkg::cmd_type              cmd,
   output bsp_pkg::status_type           status
);

   localparam int STEP_W = $clog2(MAX_NODES + 1);
   localparam int RAM_W  = $bits(bsp_pkg::node_entry_type);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_NODES - 1);

   // Node table
   bsp_pkg::node_entry_type             wr_entry, rd_entry;
   logic [RAM_W-1:0]                    ram_rdata;
   logic [bsp_pkg::NODE_AW-1:0]         node_ff, node_in;

   assign wr_entry.ox    = req_payload.part_x;
   assign wr_entry.oy    = req_payload.part_y;
   assign wr_entry.dx    = req_payload.part_dx;
   assign wr_entry.dy    = req_payload.part_dy;
   assign wr_entry.front = req_payload.front_child;
   assign wr_entry.back  = req_payload.back_child;

   bsp_ram #(
      .WIDTH (RAM_W),
      .DEPTH (bsp_pkg::TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (cmd.accept_write),
      .waddr (req_payload.node_index),
      .wdata (wr_entry),
      .re    (cmd.rd_en),
      .raddr (node_ff),
      .rdata (ram_rdata)
   );

   assign rd_entry = ram_rdata;

   // Node count register, clamped to the table depth
   logic [bsp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [bsp_pkg::NODE_AW-1:0] root;

   always_comb begin
      count_in = count_ff;
      if (csr_wr_en) begin
         count_in = (csr_wr_data > bsp_pkg::COUNT_W'(bsp_pkg::TABLE_DEPTH))
                    ? bsp_pkg::COUNT_W'(bsp_pkg::TABLE_DEPTH) : csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign root = count_ff[bsp_pkg::NODE_AW-1:0] - bsp_pkg::NODE_AW'(1);

   // Query point
   logic signed [31:0] qx_ff, qx_in, qy_ff, qy_in;

   assign qx_in = cmd.accept_query ? req_payload.query_x : qx_ff;
   assign qy_in = cmd.accept_query ? req_payload.query_y : qy_ff;

   always_ff @(posedge clock) begin
      qx_ff <= qx_in;
      qy_ff <= qy_in;
   end

   // Subtract stage: offsets, integer parts and the axis-aligned side
   logic [31:0]        rx, ry;
   logic               dx_zero, dy_zero, dx_pos, dx_neg, dy_pos, dy_neg;
   logic               fix_side;
   logic signed [15:0] rx_int_ff, rx_int_in, ry_int_ff, ry_int_in;
   logic signed [15:0] dx_int_ff, dx_int_in, dy_int_ff, dy_int_in;
   logic               use_fix_ff, use_fix_in, fix_side_ff, fix_side_in;

   always_comb begin
      rx      = qx_ff - rd_entry.ox;
      ry      = qy_ff - rd_entry.oy;
      dx_zero = (rd_entry.dx == 32'sd0);
      dy_zero = (rd_entry.dy == 32'sd0);
      dx_neg  = rd_entry.dx[31];
      dy_neg  = rd_entry.dy[31];
      dx_pos  = !dx_neg && !dx_zero;
      dy_pos  = !dy_neg && !dy_zero;
      if (dx_zero) begin
         fix_side = (qx_ff <= rd_entry.ox) ? dy_pos : dy_neg;
      end else begin
         fix_side = (qy_ff <= rd_entry.oy) ? dx_neg : dx_pos;
      end
   end

   assign rx_int_in   = cmd.sub_en ? rx[31:bsp_pkg::FRAC_BITS] : rx_int_ff;
   assign ry_int_in   = cmd.sub_en ? ry[31:bsp_pkg::FRAC_BITS] : ry_int_ff;
   assign dx_int_in   = cmd.sub_en ? rd_entry.dx[31:bsp_pkg::FRAC_BITS] : dx_int_ff;
   assign dy_int_in   = cmd.sub_en ? rd_entry.dy[31:bsp_pkg::FRAC_BITS] : dy_int_ff;
   assign use_fix_in  = cmd.sub_en ? (dx_zero || dy_zero) : use_fix_ff;
   assign fix_side_in = cmd.sub_en ? fix_side : fix_side_ff;

   always_ff @(posedge clock) begin
      rx_int_ff   <= rx_int_in;
      ry_int_ff   <= ry_int_in;
      dx_int_ff   <= dx_int_in;
      dy_int_ff   <= dy_int_in;
      use_fix_ff  <= use_fix_in;
      fix_side_ff <= fix_side_in;
   end

   // Multiply stage: cross products of the integer parts
   logic signed [31:0] left_ff, left_in, right_ff, right_in;

   assign left_in  = cmd.mul_en ? (dy_int_ff * rx_int_ff) : left_ff;
   assign right_in = cmd.mul_en ? (ry_int_ff * dx_int_ff) : right_ff;

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   // Decide stage: pick the child, stop at a leaf or at the step cap
   logic              side;
   logic [15:0]       child;
   logic              leaf, cap_hit;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [bsp_pkg::SUB_W-1:0] sub_ff, sub_in;
   logic              err_ff, err_in;

   always_comb begin
      side    = use_fix_ff ? fix_side_ff : !(right_ff < left_ff);
      child   = side ? rd_entry.back : rd_entry.front;
      leaf    = child[bsp_pkg::LEAF_BIT];
      cap_hit = (step_ff == STEP_LAST);
   end

   always_comb begin
      node_in = node_ff;
      step_in = step_ff;
      sub_in  = sub_ff;
      err_in  = err_ff;
      if (cmd.accept_query) begin
         node_in = root;
         step_in = '0;
         sub_in  = '0;
         err_in  = 1'b0;
      end else if (cmd.decide_en) begin
         node_in = child[bsp_pkg::NODE_AW-1:0];
         step_in = cap_hit ? step_ff : step_ff + STEP_W'(1);
         sub_in  = leaf ? child[bsp_pkg::SUB_W-1:0] : '0;
         err_in  = !leaf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      node_ff <= node_in;
      sub_ff  <= sub_in;
      err_ff  <= err_in;
   end

   // Response register: load when free, drop once taken
   logic             rsp_valid_ff, rsp_valid_in;
   bsp_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in               = 1'b1;
         rsp_in.subsector_index     = sub_ff;
         rsp_in.walk_error          = err_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign status.count_zero = (count_ff == '0);
   assign status.walk_done  = leaf || cap_hit;
   assign status.rsp_free   = rsp_free;

   // Checks
   `BSP_ASSERT_SAME(a_err_zero_index, clock, reset,
      rsp_valid_ff && rsp_ff.walk_error, rsp_ff.subsector_index == '0)
   `BSP_ASSERT_SAME(a_load_when_free, clock, reset, cmd.load_rsp, rsp_free)
   `BSP_ASSERT_SAME(a_step_bound, clock, reset, 1'b1, step_ff <= STEP_LAST)
   `BSP_ASSERT_NEXT(a_walk_from_root, clock, reset,
      cmd.accept_query && !csr_wr_en, node_ff == $past(root))

endmodule

[hw/rtl/bsp_point_locator.sv]
// Top level of the BSP point locator: controller, datapath and node table.
//
// Usage: a request with mode 0 writes one node entry (origin, direction,
// front and back child words) into slot node_index; it gives no response.
// A request with mode 1 locates query_x/query_y and gives one response
// holding the leaf's subsector index, or walk_error set when MAX_NODES
// nodes were visited without reaching a leaf. csr_wr_en/csr_wr_data set
// the node count (values above 4096 are stored as 4096); write it only
// while no query is in flight.
// Sequence: a query steps through ST_READ, ST_SUB, ST_MUL and ST_DECIDE
// for each node visited and then ST_FINISH, where the response loads; on
// an empty table it goes straight to ST_FINISH. The next request is taken
// in the cycle after the response loads. Each node costs a
// table read, a subtract, a multiply and a decide step of one shared
// datapath, and one request is walked at a time.
// Reset clears the node count, the walk controller and the response
// register; the node table keeps its contents and needs no clearing.
// A stalled response stays in its register; the next request is still
// accepted, and its result waits until the register frees.
module bsp_point_locator #(
   parameter int MAX_NODES = bsp_pkg::MAX_NODES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bsp_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bsp_pkg::rsp_type            rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [bsp_pkg::COUNT_W-1:0] csr_wr_data
);

   bsp_pkg::cmd_type    cmd;
   bsp_pkg::status_type status;

   bsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_payload.mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsp_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
